### hdl/linear_scan_priority_queue_assert.svh
// assertion macros shared by the priority queue rtl
// expects i_clk and i_rst_n in the scope of each use
`ifndef LINEAR_SCAN_PRIORITY_QUEUE_ASSERT_SVH
`define LINEAR_SCAN_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LSPQ_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define LSPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/lspq_pkg.sv
// shared types and constants of the linear scan priority queue
// no dependencies
`default_nettype none

package lspq_pkg;

    localparam int LSPQ_CAPACITY      = 64;
    localparam int LSPQ_PRIORITY_BITS = 8;
    localparam int VALUE_BITS         = 32;
    localparam int IN_PRIO_BITS       = 8;
    localparam int OP_BITS            = 2;
    localparam int STATUS_BITS        = 2;
    localparam int CMD_FIFO_DEPTH     = 2;

    localparam logic [OP_BITS-1:0] OP_ENQUEUE = 2'd0;
    localparam logic [OP_BITS-1:0] OP_DEQUEUE = 2'd1;
    localparam logic [OP_BITS-1:0] OP_PEEK    = 2'd2;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // what the back end has to do with one request
    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_WRITE,
        CMD_SCAN,
        CMD_REMOVE
    } t_cmd_kind;

    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_SCAN,
        ENG_SHIFT
    } t_eng_state;

endpackage

`default_nettype wire

### hdl/lspq_req_if.sv
// request channel: valid/ready handshake with operation, value and priority
// depends on lspq_pkg
`default_nettype none

interface lspq_req_if;
    import lspq_pkg::*;

    logic                         valid;
    logic                         ready;
    logic [OP_BITS-1:0]           operation;
    logic signed [VALUE_BITS-1:0] item_value;
    logic [IN_PRIO_BITS-1:0]      item_priority;

    modport source (output valid, operation, item_value, item_priority, input ready);
    modport sink   (input valid, operation, item_value, item_priority, output ready);
endinterface

`default_nettype wire

### hdl/lspq_rsp_if.sv
// response channel: valid/ready handshake with value, status and occupancy
// depends on lspq_pkg
`default_nettype none

interface lspq_rsp_if #(
    parameter int OCC_BITS = $clog2(lspq_pkg::LSPQ_CAPACITY + 1)
);
    import lspq_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] result_value;
    logic [STATUS_BITS-1:0]       status;
    logic [OCC_BITS-1:0]          occupancy;

    modport source (output valid, result_value, status, occupancy, input ready);
    modport sink   (input valid, result_value, status, occupancy, output ready);
endinterface

`default_nettype wire

### hdl/lspq_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module lspq_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

### hdl/lspq_cmd_fifo.sv
// short command queue between the request front end and the execution engine
// no dependencies
`default_nettype none

module lspq_cmd_fifo #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push_valid,
    output logic                  o_push_ready,
    input  wire logic [WIDTH-1:0] i_push_data,
    output logic                  o_pop_valid,
    input  wire logic             i_pop_ready,
    output logic      [WIDTH-1:0] o_pop_data
);

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]  r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [FILL_W-1:0] r_fill;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_fill != FILL_W'(DEPTH));
    assign o_pop_valid  = (r_fill != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (push && !pop) begin
                r_fill <= r_fill + FILL_W'(1);
            end else if (pop && !push) begin
                r_fill <= r_fill - FILL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

### hdl/lspq_front.sv
// request front end: accepts requests, tracks occupancy and classifies each one
// depends on lspq_pkg, lspq_req_if and the assertion header
`default_nettype none
`include "linear_scan_priority_queue_assert.svh"

module lspq_front #(
    parameter int CAPACITY      = lspq_pkg::LSPQ_CAPACITY,
    parameter int PRIORITY_BITS = lspq_pkg::LSPQ_PRIORITY_BITS,
    parameter int CNT_W         = $clog2(CAPACITY + 1)
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    lspq_req_if.sink    i_req,
    output logic        o_push_valid,
    input  wire logic   i_push_ready,
    output logic [lspq_pkg::VALUE_BITS + PRIORITY_BITS + 2 * CNT_W
                  + lspq_pkg::STATUS_BITS + 1:0] o_push_cmd
);
    import lspq_pkg::*;

    typedef struct packed {
        t_cmd_kind                    kind;
        t_status                      status;
        logic signed [VALUE_BITS-1:0] value;
        logic [PRIORITY_BITS-1:0]     prio;
        logic [CNT_W-1:0]             count;
        logic [CNT_W-1:0]             occ;
    } t_cmd;

    logic [CNT_W-1:0]                          r_count;
    t_cmd                                      cmd;
    logic                                      accept;
    logic [PRIORITY_BITS+IN_PRIO_BITS-1:0]     prio_wide;

    // keep only the low priority bits, zero-filled when the store is wider
    assign prio_wide = {{PRIORITY_BITS{1'b0}}, i_req.item_priority};

    always_comb begin
        cmd        = '0;
        cmd.kind   = CMD_NONE;
        cmd.status = ST_OK;
        cmd.value  = i_req.item_value;
        cmd.prio   = prio_wide[PRIORITY_BITS-1:0];
        cmd.count  = r_count;
        cmd.occ    = r_count;
        unique case (i_req.operation)
            OP_ENQUEUE: begin
                if (r_count == CNT_W'(CAPACITY)) begin
                    cmd.status = ST_FULL;
                end else begin
                    cmd.kind = CMD_WRITE;
                    cmd.occ  = r_count + CNT_W'(1);
                end
            end
            OP_DEQUEUE: begin
                if (r_count == '0) begin
                    cmd.status = ST_EMPTY;
                end else begin
                    cmd.kind = CMD_REMOVE;
                    cmd.occ  = r_count - CNT_W'(1);
                end
            end
            OP_PEEK: begin
                if (r_count == '0) begin
                    cmd.status = ST_EMPTY;
                end else begin
                    cmd.kind = CMD_SCAN;
                end
            end
            default: begin
                // spare code: no operation
            end
        endcase
    end

    assign accept       = i_req.valid && i_push_ready;
    assign i_req.ready  = i_push_ready;
    assign o_push_valid = i_req.valid;
    assign o_push_cmd   = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (accept) begin
            r_count <= cmd.occ;
        end
    end

    `LSPQ_ASSERT(a_count_bound, 1'b1, r_count <= CNT_W'(CAPACITY), "occupancy above capacity")
    `LSPQ_ASSERT_NEXT(a_count_follows, accept, r_count == $past(cmd.occ), "occupancy lost")

endmodule

`default_nettype wire

### hdl/lspq_engine.sv
// execution engine: entry ram, linear priority scan, compaction and result register
// depends on lspq_pkg, lspq_ram, lspq_rsp_if and the assertion header
`default_nettype none
`include "linear_scan_priority_queue_assert.svh"

module lspq_engine #(
    parameter int CAPACITY      = lspq_pkg::LSPQ_CAPACITY,
    parameter int PRIORITY_BITS = lspq_pkg::LSPQ_PRIORITY_BITS,
    parameter int CNT_W         = $clog2(CAPACITY + 1)
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_cmd_valid,
    output logic        o_cmd_ready,
    input  wire logic [lspq_pkg::VALUE_BITS + PRIORITY_BITS + 2 * CNT_W
                       + lspq_pkg::STATUS_BITS + 1:0] i_cmd,
    lspq_rsp_if.source  o_rsp
);
    import lspq_pkg::*;

    localparam int ADDR_W  = $clog2(CAPACITY);
    localparam int ENTRY_W = PRIORITY_BITS + VALUE_BITS;

    typedef struct packed {
        t_cmd_kind                    kind;
        t_status                      status;
        logic signed [VALUE_BITS-1:0] value;
        logic [PRIORITY_BITS-1:0]     prio;
        logic [CNT_W-1:0]             count;
        logic [CNT_W-1:0]             occ;
    } t_cmd;

    t_eng_state                   r_state, n_state;
    t_cmd                         r_cmd, n_cmd;
    t_cmd                         in_cmd;
    logic [CNT_W-1:0]             r_rd_idx, n_rd_idx;
    logic [CNT_W-1:0]             r_cmp_idx, n_cmp_idx;
    logic [CNT_W-1:0]             r_best_idx, n_best_idx;
    logic signed [VALUE_BITS-1:0] r_best_val, n_best_val;
    logic [PRIORITY_BITS-1:0]     r_best_prio, n_best_prio;
    logic [CNT_W-1:0]             r_k, n_k;

    logic                         r_out_valid;
    logic signed [VALUE_BITS-1:0] r_out_val;
    t_status                      r_out_status;
    logic [CNT_W-1:0]             r_out_occ;

    logic                         out_free;
    logic                         pop;
    logic                         out_load;
    logic signed [VALUE_BITS-1:0] out_val;
    t_status                      out_status;
    logic [CNT_W-1:0]             out_occ;

    logic [CNT_W-1:0]             rd_idx;
    logic [ADDR_W-1:0]            rd_addr;
    logic                         wr_en;
    logic [CNT_W-1:0]             wr_idx;
    logic [ENTRY_W-1:0]           wr_data;
    logic [ENTRY_W-1:0]           rd_data;
    logic [PRIORITY_BITS-1:0]     rd_prio;
    logic signed [VALUE_BITS-1:0] rd_val;

    logic [CNT_W-1:0]             last_idx;
    logic                         take;
    logic [CNT_W-1:0]             sel_idx;
    logic signed [VALUE_BITS-1:0] sel_val;
    logic [PRIORITY_BITS-1:0]     sel_prio;
    logic                         scan_last;
    logic                         need_shift;
    logic                         shift_done;

    assign in_cmd = i_cmd;

    // entries live in slots 0 .. count-1, oldest first
    lspq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_idx[ADDR_W-1:0]),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // reads past the last slot are never used, keep the address inside the ram
    assign rd_addr = (rd_idx < CNT_W'(CAPACITY)) ? rd_idx[ADDR_W-1:0] : '0;
    assign {rd_prio, rd_val} = rd_data;

    assign out_free    = !r_out_valid || o_rsp.ready;
    assign o_cmd_ready = (r_state == ENG_IDLE) && out_free;
    assign pop         = i_cmd_valid && o_cmd_ready;

    // scan compare: strictly greater keeps the oldest on a tie
    assign last_idx   = r_cmd.count - CNT_W'(1);
    assign take       = (r_cmp_idx == '0) || (rd_prio > r_best_prio);
    assign sel_idx    = take ? r_cmp_idx : r_best_idx;
    assign sel_val    = take ? rd_val : r_best_val;
    assign sel_prio   = take ? rd_prio : r_best_prio;
    assign scan_last  = (r_cmp_idx == last_idx);
    assign need_shift = (r_cmd.kind == CMD_REMOVE) && (sel_idx != last_idx);
    assign shift_done = (r_k + CNT_W'(2) == r_cmd.count);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ENG_IDLE: begin
                if (pop && (in_cmd.kind == CMD_SCAN || in_cmd.kind == CMD_REMOVE)) begin
                    n_state = ENG_SCAN;
                end
            end
            ENG_SCAN: begin
                if (scan_last) begin
                    n_state = need_shift ? ENG_SHIFT : ENG_IDLE;
                end
            end
            ENG_SHIFT: begin
                if (shift_done) begin
                    n_state = ENG_IDLE;
                end
            end
            default: n_state = ENG_IDLE;
        endcase
    end

    always_comb begin
        n_cmd       = r_cmd;
        n_rd_idx    = r_rd_idx;
        n_cmp_idx   = r_cmp_idx;
        n_best_idx  = r_best_idx;
        n_best_val  = r_best_val;
        n_best_prio = r_best_prio;
        n_k         = r_k;
        rd_idx      = r_rd_idx;
        wr_en       = 1'b0;
        wr_idx      = r_k;
        wr_data     = rd_data;
        out_load    = 1'b0;
        out_val     = '0;
        out_status  = r_cmd.status;
        out_occ     = r_cmd.occ;
        unique case (r_state)
            ENG_IDLE: begin
                out_status = in_cmd.status;
                out_occ    = in_cmd.occ;
                rd_idx     = '0;
                if (pop) begin
                    n_cmd     = in_cmd;
                    n_rd_idx  = CNT_W'(1);
                    n_cmp_idx = '0;
                    case (in_cmd.kind)
                        CMD_WRITE: begin
                            wr_en    = 1'b1;
                            wr_idx   = in_cmd.count;
                            wr_data  = {in_cmd.prio, in_cmd.value};
                            out_load = 1'b1;
                        end
                        CMD_NONE: begin
                            out_load = 1'b1;
                        end
                        default: begin
                            // scan starts with slot zero in flight
                        end
                    endcase
                end
            end
            ENG_SCAN: begin
                n_rd_idx    = r_rd_idx + CNT_W'(1);
                n_cmp_idx   = r_cmp_idx + CNT_W'(1);
                n_best_idx  = sel_idx;
                n_best_val  = sel_val;
                n_best_prio = sel_prio;
                if (scan_last) begin
                    if (need_shift) begin
                        rd_idx = sel_idx + CNT_W'(1);
                        n_k    = sel_idx;
                    end else begin
                        out_load = 1'b1;
                        out_val  = sel_val;
                    end
                end
            end
            ENG_SHIFT: begin
                // move slot k+1 down into slot k, next read already issued
                wr_en  = 1'b1;
                wr_idx = r_k;
                rd_idx = r_k + CNT_W'(2);
                n_k    = r_k + CNT_W'(1);
                if (shift_done) begin
                    out_load = 1'b1;
                    out_val  = r_best_val;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ENG_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_rd_idx    <= n_rd_idx;
        r_cmp_idx   <= n_cmp_idx;
        r_best_idx  <= n_best_idx;
        r_best_val  <= n_best_val;
        r_best_prio <= n_best_prio;
        r_k         <= n_k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_val    <= out_val;
            r_out_status <= out_status;
            r_out_occ    <= out_occ;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.result_value = r_out_val;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.occupancy    = r_out_occ;

    `LSPQ_ASSERT(a_out_no_overrun, out_load, out_free, "result register overwritten")
    `LSPQ_ASSERT(a_scan_in_range, r_state == ENG_SCAN, r_cmp_idx < r_cmd.count, "scan past last entry")
    `LSPQ_ASSERT(a_shift_in_range, r_state == ENG_SHIFT, r_k + CNT_W'(2) <= r_cmd.count, "shift past last entry")

endmodule

`default_nettype wire

### hdl/linear_scan_priority_queue.sv
// Bounded max-priority queue of CAPACITY entries. Each request transfer is an enqueue, a
// dequeue or a peek and gives exactly one response transfer, in request order. A front end
// classifies requests and tracks occupancy, so full, empty and no-op cases are decided at
// once; a two-entry command queue feeds the engine, which holds the entries oldest first
// in one ram with one read and one write port. Enqueue, full, empty and no-op load the
// result register when the engine takes them. Peek scans the held entries, reading one
// entry per cycle through the ram read port. Dequeue scans likewise and then moves each
// entry above the chosen slot down by one, one entry per cycle. Requests enter the
// command queue while the engine is busy and a result waits in the output register;
// there is no clearing pass after reset.
// depends on lspq_pkg, the interfaces, lspq_front, lspq_cmd_fifo and lspq_engine
`default_nettype none

module linear_scan_priority_queue #(
    parameter int CAPACITY      = lspq_pkg::LSPQ_CAPACITY,
    parameter int PRIORITY_BITS = lspq_pkg::LSPQ_PRIORITY_BITS
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    lspq_req_if.sink    i_req,
    lspq_rsp_if.source  o_rsp
);
    import lspq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef struct packed {
        t_cmd_kind                    kind;
        t_status                      status;
        logic signed [VALUE_BITS-1:0] value;
        logic [PRIORITY_BITS-1:0]     prio;
        logic [CNT_W-1:0]             count;
        logic [CNT_W-1:0]             occ;
    } t_cmd;

    localparam int CMD_W = $bits(t_cmd);

    logic             push_valid;
    logic             push_ready;
    t_cmd             push_cmd;
    logic             pop_valid;
    logic             pop_ready;
    t_cmd             pop_cmd;

    lspq_front #(
        .CAPACITY      (CAPACITY),
        .PRIORITY_BITS (PRIORITY_BITS),
        .CNT_W         (CNT_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_cmd   (push_cmd)
    );

    lspq_cmd_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_FIFO_DEPTH)
    ) u_cmd_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_cmd),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_cmd)
    );

    lspq_engine #(
        .CAPACITY      (CAPACITY),
        .PRIORITY_BITS (PRIORITY_BITS),
        .CNT_W         (CNT_W)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (pop_valid),
        .o_cmd_ready (pop_ready),
        .i_cmd       (pop_cmd),
        .o_rsp       (o_rsp)
    );

endmodule

`default_nettype wire

### bench/lspq_checker.sv
`timescale 1ns / 100ps
// checker for the linear scan priority queue: watches both channels, predicts each response
// and compares it with what the queue returns; depends on lspq_pkg and the two interfaces

module lspq_checker (
    input  logic    i_clk,
    input  logic    i_rst_n,
    lspq_req_if     i_req,
    lspq_rsp_if     i_rsp,
    output int      o_fail_count,
    output int      o_pending
);
    import lspq_pkg::*;

    localparam int OCC_BITS   = $clog2(LSPQ_CAPACITY + 1);
    localparam int MAX_REPORT = 10;

    typedef struct {
        logic signed [VALUE_BITS-1:0]   value;
        logic [LSPQ_PRIORITY_BITS-1:0]  prio;
    } t_entry;

    typedef struct {
        logic signed [VALUE_BITS-1:0]   value;
        t_status                        status;
        logic [OCC_BITS-1:0]            occupancy;
    } t_answer;

    t_entry  held_q[$];
    t_answer answer_q[$];
    int      fails;
    int      rsp_index;

    // applies one request to the mirrored queue and returns the response it must give
    function automatic t_answer serve_request(input logic [OP_BITS-1:0] op,
                                              input logic signed [VALUE_BITS-1:0] val,
                                              input logic [IN_PRIO_BITS-1:0] prio);
        t_answer ans;
        t_entry  ent;
        int      best;
        ans.value  = '0;
        ans.status = ST_OK;
        best       = 0;
        case (op)
            OP_ENQUEUE: begin
                if (held_q.size() >= LSPQ_CAPACITY) begin
                    ans.status = ST_FULL;
                end else begin
                    ent.value = val;
                    ent.prio  = prio[LSPQ_PRIORITY_BITS-1:0];
                    held_q.push_back(ent);
                end
            end
            OP_DEQUEUE, OP_PEEK: begin
                if (held_q.size() == 0) begin
                    ans.status = ST_EMPTY;
                end else begin
                    // strict compare keeps the oldest entry on a tie
                    for (int i = 1; i < held_q.size(); i++) begin
                        if (held_q[i].prio > held_q[best].prio) best = i;
                    end
                    ans.value = held_q[best].value;
                    if (op == OP_DEQUEUE) held_q.delete(best);
                end
            end
            default: ;
        endcase
        ans.occupancy = OCC_BITS'(held_q.size());
        return ans;
    endfunction

    always @(posedge i_clk) begin : watch
        t_answer want;
        if (i_rst_n) begin
            if (i_req.valid && i_req.ready) begin
                answer_q.push_back(serve_request(i_req.operation, i_req.item_value,
                                                 i_req.item_priority));
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (answer_q.size() == 0) begin
                    fails++;
                    if (fails <= MAX_REPORT)
                        $display("checker: response %0d unexpected: got %0d/%0d/%0d",
                                 rsp_index, i_rsp.result_value, i_rsp.status, i_rsp.occupancy);
                end else begin
                    want = answer_q.pop_front();
                    if (i_rsp.result_value !== want.value || i_rsp.status !== want.status ||
                        i_rsp.occupancy !== want.occupancy) begin
                        fails++;
                        if (fails <= MAX_REPORT)
                            $display("checker: response %0d expected %0d/%0d/%0d got %0d/%0d/%0d",
                                     rsp_index, want.value, want.status, want.occupancy,
                                     i_rsp.result_value, i_rsp.status, i_rsp.occupancy);
                    end
                end
                rsp_index++;
            end
        end
        o_pending    <= answer_q.size();
        o_fail_count <= fails;
    end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// top of the priority queue testbench: clock, reset, request stimulus, response stalls and
// verdict; depends on lspq_pkg, the interfaces, the queue rtl and lspq_checker

module tb;
    import lspq_pkg::*;

    localparam logic [OP_BITS-1:0] OP_NONE = 2'd3;
    localparam int RANDOM_ITEMS = 1900;
    localparam int IDLE_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 150;

    typedef enum logic [1:0] {PH_FILL, PH_DRAIN, PH_MIXED} t_phase;
    typedef enum logic [1:0] {PRIO_ANY, PRIO_TIES, PRIO_EXTREMES} t_prio_mix;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   idle_cycles;
    int   burst_left;

    lspq_req_if req_if ();
    lspq_rsp_if rsp_if ();

    linear_scan_priority_queue u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    lspq_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ends a run that has stopped moving
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // response side: ready runs of random length, stalls that are sometimes absent
    initial begin : receiver
        int run;
        rsp_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            run = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 80 : 20);
            repeat (run) @(negedge i_clk) rsp_if.ready <= 1'b1;
            run = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            repeat (run) @(negedge i_clk) rsp_if.ready <= 1'b0;
        end
    end

    // one request transfer; starts a new burst after a random gap when the last one ran out
    task automatic push_request(input logic [OP_BITS-1:0] op,
                                input logic signed [VALUE_BITS-1:0] val,
                                input logic [IN_PRIO_BITS-1:0] prio);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            repeat (gap) @(negedge i_clk) req_if.valid <= 1'b0;
            burst_left = $urandom_range(1, 40);
        end
        @(negedge i_clk);
        req_if.valid         <= 1'b1;
        req_if.operation     <= op;
        req_if.item_value    <= val;
        req_if.item_priority <= prio;
        do @(posedge i_clk); while (!req_if.ready);
        burst_left--;
    endtask

    // holds requests back until every response has come
    task automatic wait_all_answered();
        @(negedge i_clk) req_if.valid <= 1'b0;
        burst_left = 0;
        wait (pending == 0);
    endtask

    function automatic logic signed [VALUE_BITS-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [IN_PRIO_BITS-1:0] pick_priority(input t_prio_mix mix);
        case (mix)
            PRIO_TIES:     return IN_PRIO_BITS'($urandom_range(0, 3));
            PRIO_EXTREMES: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default:       return IN_PRIO_BITS'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin : stimulus
        t_phase             phase;
        t_prio_mix          mix;
        logic [OP_BITS-1:0] op;
        int                 sent;
        int                 phase_len;
        int                 phase_count;
        int                 roll;

        i_rst_n              = 1'b0;
        req_if.valid         = 1'b0;
        req_if.operation     = OP_ENQUEUE;
        req_if.item_value    = '0;
        req_if.item_priority = '0;
        burst_left           = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty queue, then extremes, ties and draining past empty
        push_request(OP_PEEK, $urandom, IN_PRIO_BITS'($urandom));
        push_request(OP_DEQUEUE, $urandom, IN_PRIO_BITS'($urandom));
        push_request(OP_NONE, '1, 8'hFF);
        push_request(OP_ENQUEUE, 32'sh7FFF_FFFF, 8'h00);
        push_request(OP_ENQUEUE, 32'sh8000_0000, 8'hFF);
        push_request(OP_ENQUEUE, '0, 8'hFF);
        push_request(OP_ENQUEUE, '1, 8'h80);
        push_request(OP_ENQUEUE, 32'sh5555_5555, 8'hAA);
        push_request(OP_ENQUEUE, 32'shAAAA_AAAA, 8'h55);
        push_request(OP_NONE, 32'sh1234_5678, 8'h01);
        push_request(OP_PEEK, $urandom, IN_PRIO_BITS'($urandom));
        repeat (6) push_request(OP_DEQUEUE, $urandom, IN_PRIO_BITS'($urandom));
        push_request(OP_DEQUEUE, $urandom, IN_PRIO_BITS'($urandom));
        push_request(OP_PEEK, $urandom, IN_PRIO_BITS'($urandom));

        // phases that push the queue towards full, towards empty, or hover around the middle
        sent        = 0;
        phase_count = 0;
        while (sent < RANDOM_ITEMS) begin
            phase     = t_phase'($urandom_range(0, 2));
            mix       = t_prio_mix'($urandom_range(0, 2));
            phase_len = $urandom_range(20, 120);
            repeat (phase_len) begin
                roll = $urandom_range(0, 99);
                case (phase)
                    PH_FILL:  op = (roll < 82) ? OP_ENQUEUE : (roll < 92) ? OP_DEQUEUE :
                                   (roll < 98) ? OP_PEEK : OP_NONE;
                    PH_DRAIN: op = (roll < 22) ? OP_ENQUEUE : (roll < 80) ? OP_DEQUEUE :
                                   (roll < 97) ? OP_PEEK : OP_NONE;
                    default:  op = (roll < 45) ? OP_ENQUEUE : (roll < 80) ? OP_DEQUEUE :
                                   (roll < 96) ? OP_PEEK : OP_NONE;
                endcase
                push_request(op, pick_value(), pick_priority(mix));
                sent++;
            end
            if (phase_count == 0 || $urandom_range(0, 4) == 0) wait_all_answered();
            phase_count++;
        end

        wait_all_answered();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
